// ----- rtl/ppc_pkg.sv -----
package ppc_pkg;

   typedef enum logic [2:0] {
      OP_LOAD        = 3'd0,
      OP_COMPOSE     = 3'd1,
      OP_COMPOSE_INV = 3'd2,
      OP_INVERT      = 3'd3,
      OP_DISTANCE    = 3'd4,
      OP_COMPARE     = 3'd5
   } opcode_type;

   localparam int ATAN_COUNT = 24;
   localparam logic signed [33:0] TRIG_ONE    = 34'sd1073741824;
   localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032875;

   typedef logic [31:0] atan_array_type [0:ATAN_COUNT-1];

   localparam atan_array_type ATAN_TURN = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
      32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
      32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
      32'd166886,    32'd83443,     32'd41722,     32'd20861,
      32'd10430,     32'd5215,      32'd2608,      32'd1304,
      32'd652,       32'd326,       32'd163,       32'd81
   };

endpackage

// ----- rtl/planar_pose_composer.sv -----
// Load, compare and unused opcodes go straight to the response; compose and
// invert pose take at most one CORDIC rotation pass; compose inverse at most two;
// distance at most two passes and a square root (one shared CORDIC stage, one
// shared multiplier, one root bit per cycle). One request at a time: a new one
// is taken only once the last is through, and a held response stalls the sequencer.
// Reset (synchronous) clears the pose to zero and drops any pending response.
module planar_pose_composer #(
   parameter int POS_WIDTH    = 32,
   parameter int FRAC_BITS    = 16,
   parameter int ANGLE_WIDTH  = 16,
   parameter int CORDIC_STEPS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [2:0]                    req_opcode,
   input  logic signed [POS_WIDTH-1:0]   req_in_x,
   input  logic signed [POS_WIDTH-1:0]   req_in_y,
   input  logic signed [POS_WIDTH-1:0]   req_in_z,
   input  logic [ANGLE_WIDTH-1:0]        req_in_roll,
   input  logic [ANGLE_WIDTH-1:0]        req_in_pitch,
   input  logic [ANGLE_WIDTH-1:0]        req_in_yaw,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [POS_WIDTH-1:0]   rsp_out_x,
   output logic signed [POS_WIDTH-1:0]   rsp_out_y,
   output logic signed [POS_WIDTH-1:0]   rsp_out_z,
   output logic [ANGLE_WIDTH-1:0]        rsp_out_roll,
   output logic [ANGLE_WIDTH-1:0]        rsp_out_pitch,
   output logic [ANGLE_WIDTH-1:0]        rsp_out_yaw,
   output logic [POS_WIDTH-1:0]          rsp_distance,
   output logic                          rsp_equal
);
   import ppc_pkg::*;

   localparam int PW     = POS_WIDTH;
   localparam int AW     = ANGLE_WIDTH;
   localparam int MW     = (PW > 31) ? PW : 31;
   localparam int PRW    = 2 * MW;
   localparam int CMAX   = (PW > CORDIC_STEPS) ? PW : CORDIC_STEPS;
   localparam int CW     = $clog2(CMAX + 1);
   // fraction bits are unchanged across every step; kept for the format
   localparam int FB     = FRAC_BITS;
   localparam logic [PRW-1:0] ROUND = PRW'(1) << 29;

   typedef enum logic [3:0] {
      S_IDLE, S_TRIG_START, S_ROTATE, S_TRIG_END, S_MUL, S_ACC,
      S_SQ_X, S_SQ_Y, S_SQ_SUM, S_ROOT, S_FINISH
   } state_type;

   state_type                state_ff;
   opcode_type               op_ff;
   logic signed [PW-1:0]     in_x_ff, in_y_ff, in_z_ff;
   logic [AW-1:0]            in_roll_ff, in_pitch_ff, in_yaw_ff;
   logic signed [PW-1:0]     pose_x_ff, pose_y_ff, pose_z_ff;
   logic [AW-1:0]            pose_roll_ff, pose_pitch_ff, pose_yaw_ff;
   logic signed [PW-1:0]     vec_x_ff, vec_y_ff, acc_x_ff, acc_y_ff;
   logic [AW-1:0]            ang_ff;
   logic                     inv_ff, flip_ff, neg_ff;
   logic signed [33:0]       cx_ff, cy_ff, cz_ff;
   logic signed [31:0]       cos_ff, sin_ff;
   logic [1:0]               k_ff;
   logic [CW-1:0]            cnt_ff;
   logic [PRW-1:0]           prod_ff;
   logic [2*PW-1:0]          num_ff;
   logic [PW+1:0]            rem_ff;
   logic [PW-1:0]            root_ff;
   logic                     rsp_valid_ff, rsp_equal_ff;
   logic signed [PW-1:0]     rsp_x_ff, rsp_y_ff, rsp_z_ff;
   logic [AW-1:0]            rsp_roll_ff, rsp_pitch_ff, rsp_yaw_ff;
   logic [PW-1:0]            rsp_dist_ff;

   function automatic logic [PW-1:0] mag_pos(input logic signed [PW-1:0] v);
      return v[PW-1] ? PW'(-v) : PW'(v);
   endfunction

   function automatic logic signed [33:0] clamp_trig(input logic signed [33:0] v);
      if (v > TRIG_ONE) return TRIG_ONE;
      else if (v < -TRIG_ONE) return -TRIG_ONE;
      else return v;
   endfunction

   // CORDIC angle preparation
   logic [31:0]        t_ang, t_fold;
   logic [1:0]         quad;
   logic               exact, flip;
   logic signed [33:0] cx_sh, cy_sh, cc, ss, cos_in, sin_in;
   logic [31:0]        atan;

   always_comb begin
      t_ang  = {ang_ff, (32-AW)'(0)};
      quad   = t_ang[31:30];
      exact  = (t_ang[29:0] == 30'd0);
      flip   = (quad == 2'd1) || (quad == 2'd2);
      t_fold = t_ang ^ {flip, 31'd0};
      cx_sh  = cx_ff >>> cnt_ff;
      cy_sh  = cy_ff >>> cnt_ff;
      atan   = ATAN_TURN[cnt_ff[4:0]];
      cc     = clamp_trig(cx_ff);
      ss     = clamp_trig(cy_ff);
      cos_in = flip_ff ? -cc : cc;
      sin_in = flip_ff ? -ss : ss;
   end

   // shared multiplier
   logic signed [PW-1:0] a_sel;
   logic signed [31:0]   t_sel;
   logic [31:0]          t_mag;
   logic [MW-1:0]        mul_a, mul_b;

   always_comb begin
      a_sel = k_ff[0] ? vec_y_ff : vec_x_ff;
      t_sel = (k_ff == 2'd0 || k_ff == 2'd3) ? cos_ff : sin_ff;
      t_mag = t_sel[31] ? 32'(-t_sel) : 32'(t_sel);
      priority case (state_ff)
         S_SQ_X: begin
            mul_a = MW'(mag_pos(acc_x_ff));
            mul_b = MW'(mag_pos(acc_x_ff));
         end
         S_SQ_Y: begin
            mul_a = MW'(mag_pos(acc_y_ff));
            mul_b = MW'(mag_pos(acc_y_ff));
         end
         default: begin
            mul_a = MW'(mag_pos(a_sel));
            mul_b = MW'(t_mag[30:0]);
         end
      endcase
   end

   // rounded term and accumulation
   logic [PRW-1:0]       rounded;
   logic signed [PW-1:0] term, acc_x_in, acc_y_in;
   logic                 sub;

   always_comb begin
      rounded  = prod_ff + ROUND;
      term     = neg_ff ? -$signed(rounded[30 +: PW]) : $signed(rounded[30 +: PW]);
      sub      = (k_ff == 2'd1) || (inv_ff && (k_ff == 2'd0 || k_ff == 2'd3));
      acc_x_in = acc_x_ff;
      acc_y_in = acc_y_ff;
      if (!k_ff[1]) begin
         acc_x_in = sub ? acc_x_ff - term : acc_x_ff + term;
      end else begin
         acc_y_in = sub ? acc_y_ff - term : acc_y_ff + term;
      end
   end

   // square root digit step
   logic [PW+3:0] rem_t, trial, rem_diff;
   logic          ge;

   always_comb begin
      rem_t    = {rem_ff, num_ff[2*PW-1 -: 2]};
      trial    = (PW+4)'({root_ff, 2'b01});
      ge       = (rem_t >= trial);
      rem_diff = rem_t - trial;
   end

   // pose after the step
   logic signed [PW-1:0] px_in, py_in, pz_in;
   logic [AW-1:0]        proll_in, ppitch_in, pyaw_in;
   logic [PW-1:0]        dist_in;
   logic                 eq_in;

   always_comb begin
      px_in     = pose_x_ff;
      py_in     = pose_y_ff;
      pz_in     = pose_z_ff;
      proll_in  = pose_roll_ff;
      ppitch_in = pose_pitch_ff;
      pyaw_in   = pose_yaw_ff;
      dist_in   = '0;
      eq_in     = 1'b0;
      priority case (op_ff)
         OP_LOAD: begin
            px_in     = in_x_ff;
            py_in     = in_y_ff;
            pz_in     = in_z_ff;
            proll_in  = in_roll_ff;
            ppitch_in = in_pitch_ff;
            pyaw_in   = in_yaw_ff;
         end
         OP_COMPOSE: begin
            px_in     = acc_x_ff;
            py_in     = acc_y_ff;
            pz_in     = pose_z_ff + in_z_ff;
            proll_in  = pose_roll_ff + in_roll_ff;
            ppitch_in = pose_pitch_ff + in_pitch_ff;
            pyaw_in   = pose_yaw_ff + in_yaw_ff;
         end
         OP_COMPOSE_INV: begin
            px_in   = acc_x_ff;
            py_in   = acc_y_ff;
            pyaw_in = pose_yaw_ff - in_yaw_ff;
         end
         OP_INVERT: begin
            px_in     = acc_x_ff;
            py_in     = acc_y_ff;
            pz_in     = '0;
            proll_in  = '0;
            ppitch_in = '0;
            pyaw_in   = AW'(0) - pose_yaw_ff;
         end
         OP_DISTANCE: dist_in = root_ff;
         OP_COMPARE: eq_in = (pose_x_ff == in_x_ff) && (pose_y_ff == in_y_ff) &&
                             (pose_yaw_ff == in_yaw_ff);
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_valid_ff  <= 1'b0;
         pose_x_ff     <= '0;
         pose_y_ff     <= '0;
         pose_z_ff     <= '0;
         pose_roll_ff  <= '0;
         pose_pitch_ff <= '0;
         pose_yaw_ff   <= '0;
      end else begin
         if (rsp_valid_ff && rsp_ready && state_ff != S_FINISH) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  op_ff       <= opcode_type'(req_opcode);
                  in_x_ff     <= req_in_x;
                  in_y_ff     <= req_in_y;
                  in_z_ff     <= req_in_z;
                  in_roll_ff  <= req_in_roll;
                  in_pitch_ff <= req_in_pitch;
                  in_yaw_ff   <= req_in_yaw;
                  priority case (req_opcode)
                     OP_COMPOSE: begin
                        vec_x_ff <= req_in_x;
                        vec_y_ff <= req_in_y;
                        ang_ff   <= pose_yaw_ff;
                        inv_ff   <= 1'b0;
                        state_ff <= S_TRIG_START;
                     end
                     OP_INVERT: begin
                        vec_x_ff <= pose_x_ff;
                        vec_y_ff <= pose_y_ff;
                        ang_ff   <= pose_yaw_ff;
                        inv_ff   <= 1'b1;
                        state_ff <= S_TRIG_START;
                     end
                     OP_COMPOSE_INV, OP_DISTANCE: begin
                        vec_x_ff <= req_in_x;
                        vec_y_ff <= req_in_y;
                        ang_ff   <= req_in_yaw;
                        inv_ff   <= 1'b1;
                        state_ff <= S_TRIG_START;
                     end
                     default: state_ff <= S_FINISH;
                  endcase
               end
            end
            S_TRIG_START: begin
               acc_x_ff <= inv_ff ? '0 : pose_x_ff;
               acc_y_ff <= inv_ff ? '0 : pose_y_ff;
               k_ff     <= 2'd0;
               cnt_ff   <= '0;
               flip_ff  <= flip;
               cx_ff    <= CORDIC_GAIN;
               cy_ff    <= '0;
               cz_ff    <= 34'($signed(t_fold));
               if (exact) begin
                  cos_ff   <= (quad == 2'd0) ? 32'(TRIG_ONE) :
                              (quad == 2'd2) ? 32'(-TRIG_ONE) : 32'd0;
                  sin_ff   <= (quad == 2'd1) ? 32'(TRIG_ONE) :
                              (quad == 2'd3) ? 32'(-TRIG_ONE) : 32'd0;
                  state_ff <= S_MUL;
               end else begin
                  state_ff <= S_ROTATE;
               end
            end
            S_ROTATE: begin
               if (!cz_ff[33]) begin
                  cx_ff <= cx_ff - cy_sh;
                  cy_ff <= cy_ff + cx_sh;
                  cz_ff <= cz_ff - $signed({2'b00, atan});
               end else begin
                  cx_ff <= cx_ff + cy_sh;
                  cy_ff <= cy_ff - cx_sh;
                  cz_ff <= cz_ff + $signed({2'b00, atan});
               end
               cnt_ff <= cnt_ff + CW'(1);
               if (cnt_ff == CW'(CORDIC_STEPS - 1)) state_ff <= S_TRIG_END;
            end
            S_TRIG_END: begin
               cos_ff   <= 32'(cos_in);
               sin_ff   <= 32'(sin_in);
               state_ff <= S_MUL;
            end
            S_MUL: begin
               prod_ff  <= PRW'(mul_a) * PRW'(mul_b);
               neg_ff   <= a_sel[PW-1] ^ t_sel[31];
               state_ff <= S_ACC;
            end
            S_ACC: begin
               acc_x_ff <= acc_x_in;
               acc_y_ff <= acc_y_in;
               k_ff     <= k_ff + 2'd1;
               if (k_ff != 2'd3) begin
                  state_ff <= S_MUL;
               end else if (inv_ff && op_ff != OP_INVERT) begin
                  vec_x_ff <= acc_x_in;
                  vec_y_ff <= acc_y_in;
                  ang_ff   <= pose_yaw_ff;
                  inv_ff   <= 1'b0;
                  state_ff <= S_TRIG_START;
               end else if (op_ff == OP_DISTANCE) begin
                  state_ff <= S_SQ_X;
               end else begin
                  state_ff <= S_FINISH;
               end
            end
            S_SQ_X: begin
               prod_ff  <= PRW'(mul_a) * PRW'(mul_b);
               state_ff <= S_SQ_Y;
            end
            S_SQ_Y: begin
               num_ff   <= prod_ff[2*PW-1:0];
               prod_ff  <= PRW'(mul_a) * PRW'(mul_b);
               state_ff <= S_SQ_SUM;
            end
            S_SQ_SUM: begin
               num_ff   <= num_ff + prod_ff[2*PW-1:0];
               rem_ff   <= '0;
               root_ff  <= '0;
               cnt_ff   <= '0;
               state_ff <= S_ROOT;
            end
            S_ROOT: begin
               rem_ff  <= ge ? rem_diff[PW+1:0] : rem_t[PW+1:0];
               root_ff <= {root_ff[PW-2:0], ge};
               num_ff  <= num_ff << 2;
               cnt_ff  <= cnt_ff + CW'(1);
               if (cnt_ff == CW'(PW - 1)) state_ff <= S_FINISH;
            end
            S_FINISH: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  pose_x_ff     <= px_in;
                  pose_y_ff     <= py_in;
                  pose_z_ff     <= pz_in;
                  pose_roll_ff  <= proll_in;
                  pose_pitch_ff <= ppitch_in;
                  pose_yaw_ff   <= pyaw_in;
                  rsp_x_ff      <= px_in;
                  rsp_y_ff      <= py_in;
                  rsp_z_ff      <= pz_in;
                  rsp_roll_ff   <= proll_in;
                  rsp_pitch_ff  <= ppitch_in;
                  rsp_yaw_ff    <= pyaw_in;
                  rsp_dist_ff   <= dist_in;
                  rsp_equal_ff  <= eq_in;
                  rsp_valid_ff  <= 1'b1;
                  state_ff      <= S_IDLE;
               end
            end
         endcase
      end
   end

   assign req_ready     = (state_ff == S_IDLE) && (FB >= 0);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_x     = rsp_x_ff;
   assign rsp_out_y     = rsp_y_ff;
   assign rsp_out_z     = rsp_z_ff;
   assign rsp_out_roll  = rsp_roll_ff;
   assign rsp_out_pitch = rsp_pitch_ff;
   assign rsp_out_yaw   = rsp_yaw_ff;
   assign rsp_distance  = rsp_dist_ff;
   assign rsp_equal     = rsp_equal_ff;

endmodule

// ----- rtl/ppc_checker.sv -----
module ppc_checker #(
   parameter int POS_WIDTH   = 32,
   parameter int ANGLE_WIDTH = 16
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic [POS_WIDTH-1:0]   rsp_out_x,
   input logic [ANGLE_WIDTH-1:0] rsp_out_yaw,
   input logic [POS_WIDTH-1:0]   rsp_distance,
   input logic                   rsp_equal
);
   import ppc_pkg::*;

   logic [1:0] open_ff;
   logic       req_fire, rsp_fire;

   assign req_fire = req_valid && req_ready;
   assign rsp_fire = rsp_valid && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff <= 2'd0;
      end else begin
         open_ff <= open_ff + {1'b0, req_fire} - {1'b0, rsp_fire};
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_x) &&
      $stable(rsp_out_yaw) && $stable(rsp_distance))
      else $error("response changed while stalled");

   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> open_ff != 2'd0)
      else $error("response without an open request");

   a_bounded: assert property (@(posedge clock) disable iff (reset)
      open_ff != 2'd3)
      else $error("too many open requests");

   a_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_equal |-> rsp_distance == '0)
      else $error("equal flag and distance both set");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind planar_pose_composer ppc_checker #(
   .POS_WIDTH(POS_WIDTH),
   .ANGLE_WIDTH(ANGLE_WIDTH)
) u_ppc_checker (
   .clock(clock),
   .reset(reset),
   .req_valid(req_valid),
   .req_ready(req_ready),
   .rsp_valid(rsp_valid),
   .rsp_ready(rsp_ready),
   .rsp_out_x(rsp_out_x),
   .rsp_out_yaw(rsp_out_yaw),
   .rsp_distance(rsp_distance),
   .rsp_equal(rsp_equal)
);
